// ===== rtl/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, constants and helpers of the key press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kpc_pkg;

    // Key and field widths
    localparam int NUM_KEYS      = 4;
    localparam int KEYS_W        = 4;
    localparam int KEY_NUM_W     = 3;
    localparam int TICKS_W       = 8;
    localparam int KIND_W        = 2;

    // Reset value of the long press threshold
    localparam logic [TICKS_W-1:0] LONG_TICKS_RESET = 8'd50;

    // Event codes
    typedef enum logic [KIND_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } kpc_event_t;

    // One result between the classifier and the output register
    typedef struct packed {
        kpc_event_t             kind;
        logic [KEY_NUM_W-1:0]   key_number;
    } kpc_result_t;

    // Keep only the keys that exist
    function automatic logic [KEYS_W-1:0] fitted_keys(input logic [KEYS_W-1:0] keys);
        logic [KEYS_W-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            m[i] = keys[i];
        end
        return m;
    endfunction

    // Number of the lowest held key, counting from 1; 0 when none is held
    function automatic logic [KEY_NUM_W-1:0] lowest_key(input logic [KEYS_W-1:0] keys);
        logic [KEY_NUM_W-1:0] n;
        n = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (keys[i])
            begin
                n = KEY_NUM_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/key_press_classifier.sv =====
// ----------------------------------------------------------------------------
// key_press_classifier
// Short and long press classifier for a scan of four keys.
// ----------------------------------------------------------------------------
// Usage:
//   One request on the s_ side is one scan tick; s_tdata[3:0] holds the mask
//   of held keys. Each tick yields exactly one result on the m_ side:
//   m_tuser[1:0] is the event kind (none, short press, long press) and
//   m_tdata[2:0] the key number (0 with no event).
//   cfg_we / cfg_wdata set the long press threshold in ticks; write only
//   while no tick is in flight.
//   Flow: a tick passes the input register, then the result register, and
//   leaves the result register when m_tready is high.
//   Throughput: one tick per cycle while m_tready stays high; the state
//   machine advances on each tick moved into the result register.
//   Reset clears the state machine, both valid flags and sets the threshold
//   to 50. When the receiver stalls, the result register holds its request,
//   the input register fills, and s_tready drops until m_tready returns.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_classifier (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Scan tick input
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // [3:0] held_keys, [7:4] zero
    // Event output
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [7:0]          m_tdata,    // [2:0] key_number, [7:3] zero
    output logic [1:0]          m_tuser,    // [1:0] event_kind
    // Threshold register
    input  wire logic           cfg_we,
    input  wire logic [7:0]     cfg_wdata
);

    logic                               in_valid_reg;
    logic [kpc_pkg::KEYS_W-1:0]         in_keys_reg;
    logic                               out_valid_reg;
    kpc_pkg::kpc_result_t               out_reg;
    logic [kpc_pkg::TICKS_W-1:0]        ticks_reg;

    logic                               advance;
    kpc_pkg::kpc_result_t               result;

    // Move a tick to the result register when that register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= kpc_pkg::LONG_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            ticks_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_keys_reg <= s_tdata[kpc_pkg::KEYS_W-1:0];
        end
    end

    kpc_fsm u_fsm (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .held_keys        (in_keys_reg),
        .long_press_ticks (ticks_reg),
        .result           (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - kpc_pkg::KEY_NUM_W){1'b0}}, out_reg.key_number};
    assign m_tuser  = out_reg.kind;

endmodule

`default_nettype wire

// ===== rtl/kpc_fsm.sv =====
// ----------------------------------------------------------------------------
// kpc_fsm
// Press state machine: jitter confirm, short press on release, one long press
// when the hold count reaches the threshold. Advances once per step.
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_fsm (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           step,
    input  wire logic [kpc_pkg::KEYS_W-1:0]     held_keys,
    input  wire logic [kpc_pkg::TICKS_W-1:0]    long_press_ticks,
    output kpc_pkg::kpc_result_t                result
);

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_JITTER    = 2'd1,
        ST_PRESSED   = 2'd2,
        ST_HELD_LONG = 2'd3
    } state_t;

    state_t                             state_reg,   state_next;
    logic [kpc_pkg::TICKS_W-1:0]        hold_reg,    hold_next;
    logic [kpc_pkg::KEY_NUM_W-1:0]      latch_reg,   latch_next;

    logic [kpc_pkg::KEYS_W-1:0]         keys;
    logic                               any_held;
    logic [kpc_pkg::TICKS_W-1:0]        hold_inc;
    kpc_pkg::kpc_event_t                kind;

    assign keys     = kpc_pkg::fitted_keys(held_keys);
    assign any_held = |keys;
    assign hold_inc = hold_reg + kpc_pkg::TICKS_W'(1);

    // Work out next state and the event of this tick
    always_comb
    begin
        state_next = state_reg;
        hold_next  = hold_reg;
        latch_next = any_held ? kpc_pkg::lowest_key(keys) : latch_reg;
        kind       = kpc_pkg::EV_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (any_held)
                begin
                    state_next = ST_JITTER;
                end
            end
            ST_JITTER:
            begin
                if (any_held)
                begin
                    hold_next  = '0;
                    state_next = ST_PRESSED;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRESSED:
            begin
                if (!any_held)
                begin
                    kind       = kpc_pkg::EV_SHORT;
                    state_next = ST_IDLE;
                end
                else if (hold_inc >= long_press_ticks)
                begin
                    kind       = kpc_pkg::EV_LONG;
                    state_next = ST_HELD_LONG;
                    hold_next  = '0;
                end
                else
                begin
                    hold_next = hold_inc;
                end
            end
            default:
            begin
                if (!any_held)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Result of this tick; key number only with an event
    always_comb
    begin
        result.kind       = kind;
        result.key_number = (kind == kpc_pkg::EV_NONE) ? '0 : latch_next;
    end

    // Hold state; advance on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hold_reg  <= '0;
            latch_reg <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            hold_reg  <= hold_next;
            latch_reg <= latch_next;
        end
    end

endmodule

`default_nettype wire
